### rtl/kq_pkg.sv
package kq_pkg;

   // cipher constants
   localparam int unsigned ROUND_COUNT      = 528;
   localparam int unsigned ROUNDS_PER_STAGE = 8;
   localparam int unsigned WORD_WIDTH       = 32;
   localparam int unsigned KEY_WIDTH        = 32;
   localparam logic [31:0] NLF_TABLE        = 32'h3A5C_742E;

   // command carried with each word
   typedef enum logic {
      CMD_ENCRYPT = 1'b0,
      CMD_DECRYPT = 1'b1
   } kq_cmd_type;

   // one word moving down the round pipeline
   typedef struct packed {
      logic                    valid;
      kq_cmd_type              cmd;
      logic [WORD_WIDTH-1:0]   data;
   } kq_item_type;

   // nonlinear feedback function: bit idx of the NLF constant
   function automatic logic nlf_bit(input logic [4:0] idx);
      nlf_bit = NLF_TABLE[idx];
   endfunction

endpackage

### rtl/keeloq_block_cipher.sv
// Channel   Dir  Handshake              Contents
// req       in   req_tvalid/req_tready  tdata: data_word; tuser: cmd
// rsp       out  rsp_tvalid/rsp_tready  tdata: result_word
// csr       in   csr_we                 csr_wdata: half_key
//
// Takes one word per cycle while the skid register is empty. Each word passes
// through the chain of registered round stages.
// Reset clears all valid bits, the skid one included, and the key (to zero); skid data is not reset.
// A stalled output word parks in a one-entry skid register; req_tready comes
// from that register, and the round pipeline freezes while it is full.
module keeloq_block_cipher #(
   parameter int unsigned ROUNDS_PER_STAGE = kq_pkg::ROUNDS_PER_STAGE
) (
   input  logic          clock,
   input  logic          reset,
   // input word stream
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [31:0]   req_tdata,   // [31:0] data_word
   input  logic [0:0]    req_tuser,   // [0] cmd
   // result word stream
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [31:0]   rsp_tdata,   // [31:0] result_word
   // key register write
   input  logic          csr_we,
   input  logic [31:0]   csr_wdata
);

   localparam int unsigned NUM_STAGES = kq_pkg::ROUND_COUNT / ROUNDS_PER_STAGE;

   logic [kq_pkg::KEY_WIDTH-1:0]    half_key_ff;
   logic                            skid_valid_ff;
   logic                            skid_valid_in;
   logic [kq_pkg::WORD_WIDTH-1:0]   skid_data_ff;
   logic                            en;
   kq_pkg::kq_item_type             first_item;
   kq_pkg::kq_item_type             stage_q [NUM_STAGES];
   kq_pkg::kq_item_type             last_item;

   // key register
   always_ff @(posedge clock) begin
      if (reset) begin
         half_key_ff <= '0;
      end else if (csr_we) begin
         half_key_ff <= csr_wdata;
      end
   end

   // pipeline advances whenever the skid register is empty
   assign en         = !skid_valid_ff;
   assign req_tready = en;

   assign first_item.valid = req_tvalid && en;
   assign first_item.cmd   = kq_pkg::kq_cmd_type'(req_tuser[0]);
   assign first_item.data  = req_tdata;

   // round stages
   for (genvar s = 0; s < int'(NUM_STAGES); s++) begin : g_stage
      if (s == 0) begin : g_first
         kq_stage #(
            .ROUNDS_PER_STAGE (ROUNDS_PER_STAGE),
            .FIRST_ROUND      (0)
         ) u_stage (
            .clock    (clock),
            .reset    (reset),
            .en       (en),
            .half_key (half_key_ff),
            .in_item  (first_item),
            .out_item (stage_q[s])
         );
      end else begin : g_next
         kq_stage #(
            .ROUNDS_PER_STAGE (ROUNDS_PER_STAGE),
            .FIRST_ROUND      (s * ROUNDS_PER_STAGE)
         ) u_stage (
            .clock    (clock),
            .reset    (reset),
            .en       (en),
            .half_key (half_key_ff),
            .in_item  (stage_q[s-1]),
            .out_item (stage_q[s])
         );
      end
   end

   assign last_item = stage_q[NUM_STAGES-1];

   // skid register: catches the last stage's word when the output stalls
   always_comb begin
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_tready) begin
            skid_valid_in = 1'b0;
         end
      end else if (last_item.valid && !rsp_tready) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_valid_ff) begin
         skid_data_ff <= last_item.data;
      end
   end

   // older word (skid) goes out first
   assign rsp_tvalid = skid_valid_ff || last_item.valid;
   assign rsp_tdata  = skid_valid_ff ? skid_data_ff : last_item.data;

   // skid fills only from a stalled, valid last stage
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(last_item.valid) && !$past(rsp_tready))
      else $error("skid filled without a stalled word");

   // a parked word stays until taken
   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_tready |=> skid_valid_ff && $stable(skid_data_ff))
      else $error("skid word lost while stalled");

   // a taken skid word frees the register
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp_tready |=> !skid_valid_ff)
      else $error("skid word repeated");

   // pipeline frozen while skid is full
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |=> $stable(last_item))
      else $error("pipeline moved while skid full");

   // an accepted word enters the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> stage_q[0].valid)
      else $error("accepted word not in first stage");

endmodule

### rtl/kq_stage.sv
// One pipeline stage: a group of consecutive rounds, then a register.
module kq_stage #(
   parameter int unsigned ROUNDS_PER_STAGE = kq_pkg::ROUNDS_PER_STAGE,
   parameter int unsigned FIRST_ROUND      = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic [kq_pkg::KEY_WIDTH-1:0]   half_key,
   input  kq_pkg::kq_item_type            in_item,
   output kq_pkg::kq_item_type            out_item
);

   logic                            valid_ff;
   kq_pkg::kq_cmd_type              cmd_ff;
   logic [kq_pkg::WORD_WIDTH-1:0]   data_ff;
   logic [kq_pkg::WORD_WIDTH-1:0]   data_in;

   // rounds of this stage; key bit index wraps mod 32 (key halves repeat)
   always_comb begin
      logic [kq_pkg::WORD_WIDTH-1:0] x;
      logic [4:0]                    idx;
      logic [4:0]                    kidx;
      logic                          nb;
      x = in_item.data;
      for (int j = 0; j < int'(ROUNDS_PER_STAGE); j++) begin
         unique case (in_item.cmd)
            kq_pkg::CMD_DECRYPT: begin
               idx  = {x[30], x[25], x[19], x[8], x[0]};
               kidx = 5'(15 - int'(FIRST_ROUND) - j);
               nb   = x[31] ^ x[15] ^ kq_pkg::nlf_bit(idx) ^ half_key[kidx];
               x    = {x[30:0], nb};
            end
            default: begin
               idx  = {x[31], x[26], x[20], x[9], x[1]};
               kidx = 5'(int'(FIRST_ROUND) + j);
               nb   = x[0] ^ x[16] ^ kq_pkg::nlf_bit(idx) ^ half_key[kidx];
               x    = {nb, x[31:1]};
            end
         endcase
      end
      data_in = x;
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_item.valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         cmd_ff  <= in_item.cmd;
         data_ff <= data_in;
      end
   end

   assign out_item.valid = valid_ff;
   assign out_item.cmd   = cmd_ff;
   assign out_item.data  = data_ff;

endmodule
